FILE: sv/best_match_grid_table_assert.svh
// Assertion macros for the best match grid table.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BEST_MATCH_GRID_TABLE_ASSERT_SVH
`define BEST_MATCH_GRID_TABLE_ASSERT_SVH

// same-cycle implication
`define BMGT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bmgt_pkg.sv
// Shared types and constants of the best match grid table.
// No dependencies; used by every other file of the block but the assertion macros.
`default_nettype none

package bmgt_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 8;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CNT_W    = ADDR_W + 1;
  localparam int EXT_W    = ROW_W + 1;

  typedef enum logic [1:0] {
    REQ_UPSERT = 2'd0,
    REQ_HIDE   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_PROBE  = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } state_e;

  typedef struct packed {
    req_type_e        req_type;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             matched;
    logic [15:0]      score;
    logic [15:0]      template_score;
    logic [6:0]       phash_distance;
    logic [15:0]      template_id;
    logic [8:0]       cell_index;
    logic [63:0]      screen_box;
    logic             seen_now;
  } req_t;

  typedef struct packed {
    logic             inserted;
    logic             replaced;
    logic             present;
    logic             entry_matched;
    logic             entry_visible;
    logic [15:0]      entry_template_id;
    logic [15:0]      entry_score;
    logic [8:0]       entry_cell_index;
    logic [63:0]      entry_box;
    logic [CNT_W-1:0] total_cells;
    logic [CNT_W-1:0] known_cells;
    logic [EXT_W-1:0] rows_in_use;
  } rsp_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] score;
    logic [15:0] template_score;
    logic [6:0]  phash_distance;
    logic [15:0] template_id;
  } rec_t;

  typedef struct packed {
    rec_t        rec;
    logic [8:0]  cell_index;
    logic [63:0] box;
  } entry_t;

  typedef struct packed {
    logic [MAX_COLS-1:0] present;
    logic [MAX_COLS-1:0] visible;
    logic [MAX_COLS-1:0] box_valid;
  } row_flags_t;

  typedef struct packed {
    logic rd_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/bmgt_if.sv
// Request and response channel interfaces of the best match grid table.
// Depends on bmgt_pkg for the payload types.
`default_nettype none

interface bmgt_req_if;
  logic          valid;
  logic          ready;
  bmgt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bmgt_rsp_if;
  logic          valid;
  logic          ready;
  bmgt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/bmgt_ctrl.sv
// Controller of the best match grid table: sequences lookup and finish.
// Depends on bmgt_pkg for state, command and status types.
`default_nettype none

module bmgt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire bmgt_pkg::sts_t sts_i,
  output bmgt_pkg::cmd_t      cmd_o
);

  bmgt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmgt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmgt_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = bmgt_pkg::ST_LOOK;
      end
      bmgt_pkg::ST_LOOK: begin
        if (!sts_i.out_busy) state_d = bmgt_pkg::ST_IDLE;
      end
      default: state_d = bmgt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.rd_en   = 1'b0;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      bmgt_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.rd_en = req_valid_i;
      end
      bmgt_pkg::ST_LOOK: begin
        cmd_o.finish = !sts_i.out_busy;
      end
      default: req_ready_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bmgt_dp.sv
// Datapath of the best match grid table: entry and flag memories, compare,
// counters and the response register. Depends on bmgt_pkg.
`default_nettype none

module bmgt_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bmgt_pkg::req_t req_data_i,
  input  wire bmgt_pkg::cmd_t cmd_i,
  output bmgt_pkg::sts_t      sts_o,
  input  wire logic           rsp_ready_i,
  output logic                rsp_valid_o,
  output bmgt_pkg::rsp_t      rsp_data_o
);

  bmgt_pkg::entry_t     data_mem [bmgt_pkg::CELLS];
  bmgt_pkg::row_flags_t flag_mem [bmgt_pkg::MAX_ROWS];

  bmgt_pkg::req_t       req_q;
  bmgt_pkg::entry_t     rd_data_q;
  bmgt_pkg::row_flags_t rd_flags_q;

  logic [bmgt_pkg::MAX_ROWS-1:0] row_valid_q, row_valid_d;
  logic [bmgt_pkg::MAX_ROWS-1:0] show_valid_q, show_valid_d;
  logic [bmgt_pkg::CNT_W-1:0]    stored_q, stored_d;
  logic [bmgt_pkg::CNT_W-1:0]    matched_q, matched_d;
  logic [bmgt_pkg::EXT_W-1:0]    extent_q, extent_d;
  logic                          out_valid_q;
  bmgt_pkg::rsp_t                rsp_q, rsp_d;

  logic [bmgt_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  bmgt_pkg::row_flags_t        cur_flags, wr_flags;
  bmgt_pkg::entry_t            wr_word;
  bmgt_pkg::rec_t              cand, cur;
  logic                        key_hit, win, do_insert, do_replace, take_all, wr_en;
  logic                        is_upsert, is_hide, is_read, is_probe;
  logic [bmgt_pkg::EXT_W-1:0]  row_next;

  assign rd_addr = {req_data_i.row, req_data_i.col};
  assign wr_addr = {req_q.row, req_q.col};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      req_q      <= req_data_i;
      rd_data_q  <= data_mem[rd_addr];
      rd_flags_q <= flag_mem[req_data_i.row];
    end
    if (wr_en) begin
      data_mem[wr_addr]   <= wr_word;
      flag_mem[req_q.row] <= wr_flags;
    end
  end

  assign is_upsert = (req_q.req_type == bmgt_pkg::REQ_UPSERT);
  assign is_hide   = (req_q.req_type == bmgt_pkg::REQ_HIDE);
  assign is_read   = (req_q.req_type == bmgt_pkg::REQ_READ);
  assign is_probe  = (req_q.req_type == bmgt_pkg::REQ_PROBE);

  assign cand = '{matched: req_q.matched, score: req_q.score,
                  template_score: req_q.template_score,
                  phash_distance: req_q.phash_distance,
                  template_id: req_q.template_id};
  assign cur  = rd_data_q.rec;

  always_comb begin
    cur_flags = '0;
    if (row_valid_q[req_q.row]) begin
      cur_flags.present = rd_flags_q.present;
    end
    if (show_valid_q[req_q.row]) begin
      cur_flags.visible   = rd_flags_q.visible;
      cur_flags.box_valid = rd_flags_q.box_valid;
    end
  end

  assign key_hit = cur_flags.present[req_q.col];

  always_comb begin
    if (!cand.matched) begin
      win = 1'b0;
    end else if (!cur.matched) begin
      win = 1'b1;
    end else if (cand.score != cur.score) begin
      win = (cand.score > cur.score);
    end else if (cand.template_score != cur.template_score) begin
      win = (cand.template_score > cur.template_score);
    end else if (cand.phash_distance != cur.phash_distance) begin
      win = (cand.phash_distance < cur.phash_distance);
    end else begin
      win = (cand.template_id < cur.template_id);
    end
  end

  assign do_insert  = is_upsert && !key_hit;
  assign do_replace = is_upsert && key_hit && win;
  assign take_all   = do_insert || do_replace;
  assign wr_en      = cmd_i.finish && is_upsert;

  always_comb begin
    wr_flags                     = cur_flags;
    wr_flags.present[req_q.col]   = 1'b1;
    wr_flags.box_valid[req_q.col] = 1'b1;
    wr_flags.visible[req_q.col]   = take_all ? req_q.seen_now : 1'b1;
    wr_word.rec                  = take_all ? cand : cur;
    wr_word.cell_index           = req_q.cell_index;
    wr_word.box                  = req_q.screen_box;
  end

  assign row_next = {1'b0, req_q.row} + bmgt_pkg::EXT_W'(1);

  always_comb begin
    stored_d     = stored_q;
    matched_d    = matched_q;
    extent_d     = extent_q;
    row_valid_d  = row_valid_q;
    show_valid_d = show_valid_q;
    if (cmd_i.finish) begin
      if (do_insert) begin
        stored_d = stored_q + bmgt_pkg::CNT_W'(1);
        if (row_next > extent_q) extent_d = row_next;
      end
      if ((do_insert && cand.matched) || (do_replace && !cur.matched)) begin
        matched_d = matched_q + bmgt_pkg::CNT_W'(1);
      end
      if (is_upsert) begin
        row_valid_d[req_q.row]  = 1'b1;
        show_valid_d[req_q.row] = 1'b1;
      end
      if (is_hide) begin
        show_valid_d = '0;
      end
    end
  end

  always_comb begin
    rsp_d             = '0;
    rsp_d.inserted    = do_insert || (is_probe && !key_hit);
    rsp_d.replaced    = do_replace;
    rsp_d.total_cells = stored_d;
    rsp_d.known_cells = matched_d;
    rsp_d.rows_in_use = extent_d;
    if (is_read && key_hit) begin
      rsp_d.present           = 1'b1;
      rsp_d.entry_matched     = cur.matched;
      rsp_d.entry_visible     = cur_flags.visible[req_q.col];
      rsp_d.entry_template_id = cur.template_id;
      rsp_d.entry_score       = cur.score;
      rsp_d.entry_cell_index  = rd_data_q.cell_index;
      rsp_d.entry_box         = cur_flags.box_valid[req_q.col] ? rd_data_q.box : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q  <= '0;
      show_valid_q <= '0;
      stored_q     <= '0;
      matched_q    <= '0;
      extent_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      row_valid_q  <= row_valid_d;
      show_valid_q <= show_valid_d;
      stored_q     <= stored_d;
      matched_q    <= matched_d;
      extent_q     <= extent_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) rsp_q <= rsp_d;
  end

  assign sts_o.out_busy = out_valid_q && !rsp_ready_i;
  assign rsp_valid_o    = out_valid_q;
  assign rsp_data_o     = rsp_q;

endmodule

`default_nettype wire

FILE: sv/best_match_grid_table.sv
// Best match grid table: keeps the best recognition result per grid cell.
// Channels: req_i (sink) takes one request; rsp_o (source) returns one
// response per request, carrying the flags, the read entry and the counters.
// An item is taken when valid and ready are both high on a rising clk_i.
// Each request passes through the controller's idle state, which reads the entry
// and flag memories at the cell address, and then its lookup state, which
// compares, writes back and loads the response register. Only the idle state
// takes requests, so a new request waits until the last one is finished.
// The lookup state waits until the output register is free, then loads it; rsp_o.valid rises with it.
// A new request is taken while the previous response waits in the output
// register; if the receiver still stalls when the next response is ready,
// the block holds that request and req_i.ready stays low.
// Reset (rst_ni, asynchronous, active low) clears the per-row present and
// visibility valid bits and the counters at once; no clearing pass is run.
// Hide clears all visible flags and boxes at once by clearing the per-row visibility valid bits.
// Depends on bmgt_pkg, bmgt_if, bmgt_ctrl, bmgt_dp and the assertion macros.
`default_nettype none

`include "best_match_grid_table_assert.svh"

module best_match_grid_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bmgt_req_if.sink  req_i,
  bmgt_rsp_if.source rsp_o
);

  bmgt_pkg::cmd_t cmd;
  bmgt_pkg::sts_t sts;
  logic           rsp_valid;
  bmgt_pkg::rsp_t rsp_data;

  bmgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmgt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_data_o  (rsp_data)
  );

  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

  `BMGT_ASSERT_NOW(a_known_le_total, rsp_o.valid,
    rsp_o.data.known_cells <= rsp_o.data.total_cells, "matched count exceeds total")
  `BMGT_ASSERT_NOW(a_extent_empty, rsp_o.valid,
    (rsp_o.data.total_cells == '0) == (rsp_o.data.rows_in_use == '0), "row extent mismatch")
  `BMGT_ASSERT_NOW(a_insert_xor_replace, rsp_o.valid,
    !(rsp_o.data.inserted && rsp_o.data.replaced), "inserted and replaced both set")
  `BMGT_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready,
    !req_i.ready, "request accepted while lookup in flight")

endmodule

`default_nettype wire

FILE: tb/tb_best_match_grid_table.sv
`timescale 1ns / 1ps
// Self-checking testbench of best_match_grid_table: directed, random and fill
// sequences on req_i, scoreboard prediction of every response on rsp_o.
// Depends on bmgt_pkg, bmgt_if and the best_match_grid_table RTL.

module tb_best_match_grid_table;

  localparam int LIMIT = 600000;

  class grid_table_scoreboard;
    bit                                 key_present [bmgt_pkg::CELLS];
    bmgt_pkg::rec_t                     rec_mem     [bmgt_pkg::CELLS];
    logic [8:0]                         scan_idx    [bmgt_pkg::CELLS];
    logic [63:0]                        box_mem     [bmgt_pkg::CELLS];
    bit                                 visible     [bmgt_pkg::CELLS];
    bit                                 box_ok      [bmgt_pkg::CELLS];
    logic [bmgt_pkg::CNT_W-1:0]         stored_cnt;
    logic [bmgt_pkg::CNT_W-1:0]         matched_cnt;
    logic [bmgt_pkg::EXT_W-1:0]         row_ext;
    bmgt_pkg::rsp_t                     awaited_rsps [$];
    int unsigned                        faults;
    int unsigned                        checked;
    int unsigned                        n_inserted;
    int unsigned                        n_replaced;
    int unsigned                        n_hides;

    function new();
      stored_cnt  = '0;
      matched_cnt = '0;
      row_ext     = '0;
      faults      = 0;
      checked     = 0;
      n_inserted  = 0;
      n_replaced  = 0;
      n_hides     = 0;
    endfunction

    function bit candidate_beats(bmgt_pkg::rec_t cur, bmgt_pkg::rec_t cand);
      if (!cand.matched) return 1'b0;
      if (!cur.matched) return 1'b1;
      if (cand.score != cur.score) return cand.score > cur.score;
      if (cand.template_score != cur.template_score)
        return cand.template_score > cur.template_score;
      if (cand.phash_distance != cur.phash_distance)
        return cand.phash_distance < cur.phash_distance;
      return cand.template_id < cur.template_id;
    endfunction

    function void note_request(bmgt_pkg::req_t r);
      bmgt_pkg::rsp_t              o;
      bmgt_pkg::rec_t              cand;
      logic [bmgt_pkg::ADDR_W-1:0] a;
      o = '0;
      a = {r.row, r.col};
      cand.matched        = r.matched;
      cand.score          = r.score;
      cand.template_score = r.template_score;
      cand.phash_distance = r.phash_distance;
      cand.template_id    = r.template_id;
      case (r.req_type)
        bmgt_pkg::REQ_UPSERT: begin
          if (!key_present[a]) begin
            key_present[a] = 1'b1;
            rec_mem[a]     = cand;
            scan_idx[a]    = r.cell_index;
            box_mem[a]     = r.screen_box;
            box_ok[a]      = 1'b1;
            visible[a]     = r.seen_now;
            stored_cnt     = stored_cnt + bmgt_pkg::CNT_W'(1);
            if (cand.matched) matched_cnt = matched_cnt + bmgt_pkg::CNT_W'(1);
            if (bmgt_pkg::EXT_W'(r.row) + bmgt_pkg::EXT_W'(1) > row_ext)
              row_ext = bmgt_pkg::EXT_W'(r.row) + bmgt_pkg::EXT_W'(1);
            o.inserted = 1'b1;
            n_inserted++;
          end else if (candidate_beats(rec_mem[a], cand)) begin
            if (!rec_mem[a].matched) matched_cnt = matched_cnt + bmgt_pkg::CNT_W'(1);
            rec_mem[a]  = cand;
            scan_idx[a] = r.cell_index;
            box_mem[a]  = r.screen_box;
            box_ok[a]   = 1'b1;
            visible[a]  = r.seen_now;
            o.replaced  = 1'b1;
            n_replaced++;
          end else begin
            scan_idx[a] = r.cell_index;
            box_mem[a]  = r.screen_box;
            box_ok[a]   = 1'b1;
            visible[a]  = 1'b1;
          end
        end
        bmgt_pkg::REQ_HIDE: begin
          foreach (visible[i]) begin
            visible[i] = 1'b0;
            box_ok[i]  = 1'b0;
            box_mem[i] = '0;
          end
          n_hides++;
        end
        bmgt_pkg::REQ_READ: begin
          if (key_present[a]) begin
            o.present           = 1'b1;
            o.entry_matched     = rec_mem[a].matched;
            o.entry_visible     = visible[a];
            o.entry_template_id = rec_mem[a].template_id;
            o.entry_score       = rec_mem[a].score;
            o.entry_cell_index  = scan_idx[a];
            o.entry_box         = box_ok[a] ? box_mem[a] : '0;
          end
        end
        bmgt_pkg::REQ_PROBE: o.inserted = !key_present[a];
        default: ;
      endcase
      o.total_cells = stored_cnt;
      o.known_cells = matched_cnt;
      o.rows_in_use = row_ext;
      awaited_rsps = {awaited_rsps, o};
    endfunction

    function void compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, name, want, got);
      end
    endfunction

    function void check_response(bmgt_pkg::rsp_t got);
      bmgt_pkg::rsp_t want;
      if (awaited_rsps.size() == 0) begin
        faults++;
        if (faults <= 10) $display("[%0t] response with no request pending", $realtime);
        return;
      end
      want = awaited_rsps.pop_front();
      checked++;
      compare_field("inserted", 64'(got.inserted), 64'(want.inserted));
      compare_field("replaced", 64'(got.replaced), 64'(want.replaced));
      compare_field("present", 64'(got.present), 64'(want.present));
      compare_field("entry_matched", 64'(got.entry_matched), 64'(want.entry_matched));
      compare_field("entry_visible", 64'(got.entry_visible), 64'(want.entry_visible));
      compare_field("entry_template_id", 64'(got.entry_template_id),
                    64'(want.entry_template_id));
      compare_field("entry_score", 64'(got.entry_score), 64'(want.entry_score));
      compare_field("entry_cell_index", 64'(got.entry_cell_index),
                    64'(want.entry_cell_index));
      compare_field("entry_box", got.entry_box, want.entry_box);
      compare_field("total_cells", 64'(got.total_cells), 64'(want.total_cells));
      compare_field("known_cells", 64'(got.known_cells), 64'(want.known_cells));
      compare_field("rows_in_use", 64'(got.rows_in_use), 64'(want.rows_in_use));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bmgt_req_if req_if();
  bmgt_rsp_if rsp_if();

  best_match_grid_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  grid_table_scoreboard        sb = new();
  bit                          calm;
  int unsigned                 cycles = 0;
  int unsigned                 sent;
  logic [bmgt_pkg::ADDR_W-1:0] hot_keys [12];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               sb.awaited_rsps.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  initial begin
    int stall;
    int p;
    rsp_if.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        rsp_if.ready <= 1'b1;
      end else if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 60) begin
          rsp_if.ready <= 1'b1;
        end else begin
          rsp_if.ready <= 1'b0;
          stall = (p < 92) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic int next_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_phash();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd64;
      default: return 7'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic bmgt_pkg::req_t mk(bmgt_pkg::req_type_e t, int row, int col, bit m,
                                        int s, int ts, int ph, int id, int cidx,
                                        logic [63:0] box, bit seen);
    bmgt_pkg::req_t r;
    r.req_type       = t;
    r.row            = bmgt_pkg::ROW_W'(row);
    r.col            = bmgt_pkg::COL_W'(col);
    r.matched        = m;
    r.score          = 16'(s);
    r.template_score = 16'(ts);
    r.phash_distance = 7'(ph);
    r.template_id    = 16'(id);
    r.cell_index     = 9'(cidx);
    r.screen_box     = box;
    r.seen_now       = seen;
    return r;
  endfunction

  function automatic bmgt_pkg::req_t random_request();
    bmgt_pkg::req_t              r;
    bmgt_pkg::rec_t              cur;
    logic [bmgt_pkg::ADDR_W-1:0] a;
    int                          p;
    int                          lvl;
    p = $urandom_range(0, 99);
    if (p < 56) r.req_type = bmgt_pkg::REQ_UPSERT;
    else if (p < 80) r.req_type = bmgt_pkg::REQ_READ;
    else if (p < 96) r.req_type = bmgt_pkg::REQ_PROBE;
    else r.req_type = bmgt_pkg::REQ_HIDE;
    if ($urandom_range(0, 99) < 55) a = hot_keys[$urandom_range(0, 11)];
    else a = bmgt_pkg::ADDR_W'($urandom_range(0, bmgt_pkg::CELLS - 1));
    {r.row, r.col}   = a;
    r.matched        = ($urandom_range(0, 9) < 8);
    r.score          = pick16();
    r.template_score = pick16();
    r.phash_distance = pick_phash();
    r.template_id    = pick16();
    r.cell_index     = 9'($urandom_range(0, 511));
    r.screen_box     = {$urandom, $urandom};
    r.seen_now       = 1'($urandom_range(0, 1));
    // tie the candidate to the stored record up to a random depth of the order
    if (r.req_type == bmgt_pkg::REQ_UPSERT && sb.key_present[a]) begin
      cur = sb.rec_mem[a];
      lvl = $urandom_range(0, 4);
      if (lvl >= 1) r.score = cur.score;
      if (lvl >= 2) r.template_score = cur.template_score;
      if (lvl >= 3) r.phash_distance = cur.phash_distance;
      if (lvl >= 4) r.template_id = cur.template_id;
    end
    return r;
  endfunction

  task automatic send_req(input bmgt_pkg::req_t r);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    sent++;
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited_rsps.size() != 0);
  endtask

  initial begin
    bmgt_pkg::req_t r;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    calm   = 1'b0;
    sent   = 0;
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    for (int i = 2; i < 12; i++)
      hot_keys[i] = bmgt_pkg::ADDR_W'($urandom_range(0, bmgt_pkg::CELLS - 1));
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(mk(bmgt_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_PROBE, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 0, 'hFFFF, 'hFFFF, 0, 0, 3,
                64'h0123_4567_89AB_CDEF, 1));
    send_req(mk(bmgt_pkg::REQ_PROBE, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 1, 0, 0, 64, 'hFFFF, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 0, 'hFFFF, 'hFFFF, 0, 0, 17,
                64'hDEAD_BEEF_0000_0001, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 1, 1, 0, 64, 'hFFFF, 18, 64'h1, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 1, 1, 1, 64, 'hFFFF, 19, 64'h2, 1));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 1, 1, 1, 63, 'hFFFF, 20, 64'h3, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 1, 1, 1, 63, 'hFFFE, 21, 64'h4, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 1, 1, 1, 63, 'hFFFE, 22, 64'h5, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 1, 0, 'hFFFF, 0, 0, 23, 64'h6, 0));
    send_req(mk(bmgt_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 63, 7, 1, 'hFFFF, 'hFFFF, 64, 'hFFFF, 511, '1, 1));
    send_req(mk(bmgt_pkg::REQ_READ, 63, 7, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_PROBE, 63, 7, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_READ, 63, 7, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 0, 0, 0, 0, 0, 0, 0, 300,
                64'hA5A5_5A5A_F0F0_0F0F, 0));
    send_req(mk(bmgt_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_UPSERT, 63, 7, 1, 'hFFFF, 'hFFFF, 0, 'hFFFF, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_READ, 63, 7, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    send_req(mk(bmgt_pkg::REQ_PROBE, 5, 3, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    wait_drain();

    for (int n = 0; n < 420; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 200) wait_drain();
      send_req(random_request());
    end

    // fill every remaining cell so the counters reach the full table
    calm = 1'b0;
    for (int i = 0; i < bmgt_pkg::CELLS; i++) begin
      if (!sb.key_present[i]) begin
        r = random_request();
        r.req_type = bmgt_pkg::REQ_UPSERT;
        {r.row, r.col} = bmgt_pkg::ADDR_W'(i);
        send_req(r);
      end
      if (i % 8 == 0) begin
        r = random_request();
        r.req_type = bmgt_pkg::REQ_READ;
        send_req(r);
      end
    end
    send_req(mk(bmgt_pkg::REQ_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 0));
    for (int n = 0; n < 40; n++) send_req(random_request());

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (sb.awaited_rsps.size() != 0) begin
      $display("%0d responses never arrived", sb.awaited_rsps.size());
      sb.faults += sb.awaited_rsps.size();
    end
    $display("Sent %0d requests, checked %0d responses: %0d inserts, %0d replacements,",
             sent, sb.checked, sb.n_inserted, sb.n_replaced);
    $display("%0d hides, table ended with %0d cells (%0d matched), %0d faults.",
             sb.n_hides, sb.stored_cnt, sb.matched_cnt, sb.faults);
    if (sb.faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
